[rtl/adf_pkg.sv]
`timescale 1ns / 1ps

package adf_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int ADDR_W   = 64;
    localparam int FAMILY_W = 2;
    localparam int POS_W    = 4;
    localparam int KEPT_W   = 5;

    localparam int S_DATA_W = 2 * ADDR_W;
    localparam int S_USER_W = 1 + FAMILY_W;
    localparam int M_USER_W = 3;
    localparam int M_DATA_W = 16;
    localparam int M_PAD_W  = M_DATA_W - POS_W - KEPT_W;

    localparam logic [FAMILY_W-1:0] FAM_IPV4 = 2'd0;
    localparam logic [FAMILY_W-1:0] FAM_IPV6 = 2'd1;

    typedef enum logic [1:0] {
        VERDICT_KEPT        = 2'd0,
        VERDICT_DUPLICATE   = 2'd1,
        VERDICT_UNSUPPORTED = 2'd2,
        VERDICT_FULL        = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              is_v6;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
    } entry_t;

endpackage

[rtl/adf_entry_ram.sv]
`timescale 1ns / 1ps

module adf_entry_ram
    import adf_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem_reg [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/address_list_dedup_filter.sv]
`timescale 1ns / 1ps
// duplicate filter for address lists
// input channel s_*: one request per address, tuser carries the start of list
// flag and the family, tdata the 128-bit address; start of list empties the table
// result channel m_*: one result per request, tuser carries keep and verdict,
// tdata the kept position and the number of entries held after the request
// the table lives in a single-port-read entry memory of MAX_ENTRIES rows; each
// request reads the held entries one per cycle and stops at the first match
// with no match a request reads every held entry, and each read entry is compared
// as it returns; then the verdict is decided and registered, and the result
// register loads; an unsupported family or an empty table skips the reads, and
// a match at entry i ends the scan there
// the next request is taken in the cycle after the result register loads
// s_tready is high only while no request is in work; one finished result may
// wait in the output register while the next request is taken in
// a stalled receiver holds the result and, once the next request has been
// worked through, holds s_tready low until the output register frees
// reset empties the table and drops any result still held

module address_list_dedup_filter
    import adf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // addr_high, addr_low
    input  logic [S_USER_W-1:0] s_tuser,   // start_of_list, family
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // position, kept_count, zero pad
    output logic [M_USER_W-1:0] m_tuser    // keep, verdict
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;

    logic              item_v6_reg;
    logic              item_unsup_reg;
    logic [ADDR_W-1:0] item_high_reg;
    logic [ADDR_W-1:0] item_low_reg;
    verdict_t          res_verdict_reg;
    logic [IDX_W-1:0]  res_pos_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;

    logic              accept;
    logic              rd_en;
    logic              wr_en;
    logic              decide;
    logic              out_load;
    logic              hit;
    logic              scan_end;
    logic              table_full;
    verdict_t          verdict_next;
    entry_t            rd_entry;
    entry_t            wr_entry;
    logic [FAMILY_W-1:0] s_family;

    assign s_family   = s_tuser[FAMILY_W:1];
    assign accept     = s_tvalid && s_tready;
    assign table_full = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign scan_end   = (idx_reg == count_reg) && !pend_reg;

    assign hit = pend_reg && (rd_entry.is_v6 == item_v6_reg) &&
                 (item_v6_reg ? (rd_entry.addr_high == item_high_reg &&
                                 rd_entry.addr_low == item_low_reg)
                              : (rd_entry.addr_high[ADDR_W-1:32] ==
                                 item_high_reg[ADDR_W-1:32]));

    always_comb begin
        if (item_unsup_reg) begin
            verdict_next = VERDICT_UNSUPPORTED;
        end else if (hit) begin
            verdict_next = VERDICT_DUPLICATE;
        end else if (table_full) begin
            verdict_next = VERDICT_FULL;
        end else begin
            verdict_next = VERDICT_KEPT;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (item_unsup_reg || hit || scan_end) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        decide   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SCAN: begin
                rd_en  = !item_unsup_reg && !hit && (idx_reg < count_reg);
                decide = item_unsup_reg || hit || scan_end;
            end
            ST_EMIT: begin
                out_load = !m_valid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign wr_en = decide && (verdict_next == VERDICT_KEPT);

    assign wr_entry.is_v6     = item_v6_reg;
    assign wr_entry.addr_high = item_v6_reg ? item_high_reg
                                            : {item_high_reg[ADDR_W-1:32], 32'b0};
    assign wr_entry.addr_low  = item_v6_reg ? item_low_reg : '0;

    adf_entry_ram u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    always_comb begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        pend_next    = rd_en;
        m_valid_next = m_valid_reg;
        if (accept) begin
            idx_next = '0;
            if (s_tuser[0]) begin
                count_next = '0;
            end
        end
        if (rd_en) begin
            idx_next = idx_reg + 1'b1;
        end
        if (wr_en) begin
            count_next = count_reg + 1'b1;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_v6_reg    <= (s_family == FAM_IPV6);
            item_unsup_reg <= (s_family != FAM_IPV4) && (s_family != FAM_IPV6);
            item_high_reg  <= s_tdata[ADDR_W-1:0];
            item_low_reg   <= s_tdata[S_DATA_W-1:ADDR_W];
        end
        if (decide) begin
            res_verdict_reg <= verdict_next;
            res_pos_reg     <= (verdict_next == VERDICT_KEPT) ? count_reg[IDX_W-1:0] : '0;
        end
        if (out_load) begin
            m_user_reg <= {res_verdict_reg, (res_verdict_reg == VERDICT_KEPT)};
            m_data_reg <= {{M_PAD_W{1'b0}}, KEPT_W'(count_reg), POS_W'(res_pos_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

[test/tb_address_list_dedup_filter.sv]
`timescale 1ns / 1ps

module tb_address_list_dedup_filter;
    import adf_pkg::*;

    localparam logic [FAMILY_W-1:0] FAM_UNSUP_A = 2'd2;
    localparam logic [FAMILY_W-1:0] FAM_UNSUP_B = 2'd3;
    localparam int POOL_MAX = 20;

    typedef struct {
        logic              keep;
        verdict_t          verdict;
        logic [POS_W-1:0]  position;
        logic [KEPT_W-1:0] kept_count;
    } verdict_rec_t;

    class dedup_scoreboard;
        logic              slot_v6 [MAX_ENTRIES];
        logic [ADDR_W-1:0] slot_hi [MAX_ENTRIES];
        logic [ADDR_W-1:0] slot_lo [MAX_ENTRIES];
        int unsigned       held_count;
        verdict_rec_t      awaited_verdicts[$];
        int                mismatch_count;
        int                request_count;
        int                list_starts;
        int                verdict_tally [4];

        function new();
            held_count     = 0;
            mismatch_count = 0;
            request_count  = 0;
            list_starts    = 0;
            foreach (verdict_tally[k]) verdict_tally[k] = 0;
        endfunction

        function int pending();
            return awaited_verdicts.size();
        endfunction

        function verdict_rec_t predict_verdict(logic sol, logic [FAMILY_W-1:0] fam,
                                               logic [ADDR_W-1:0] hi,
                                               logic [ADDR_W-1:0] lo);
            verdict_rec_t r;
            logic         v6;
            logic         dup;
            v6           = (fam == FAM_IPV6);
            dup          = 1'b0;
            r.keep       = 1'b0;
            r.position   = '0;
            if (sol) held_count = 0;
            if (fam > FAM_IPV6) begin
                r.verdict = VERDICT_UNSUPPORTED;
            end else begin
                for (int i = 0; i < held_count; i++) begin
                    if (slot_v6[i] == v6) begin
                        if (v6 ? (slot_hi[i] == hi && slot_lo[i] == lo)
                               : (slot_hi[i][63:32] == hi[63:32]))
                            dup = 1'b1;
                    end
                end
                if (dup) begin
                    r.verdict = VERDICT_DUPLICATE;
                end else if (held_count >= MAX_ENTRIES) begin
                    r.verdict = VERDICT_FULL;
                end else begin
                    slot_v6[held_count] = v6;
                    slot_hi[held_count] = v6 ? hi : {hi[63:32], 32'h0};
                    slot_lo[held_count] = v6 ? lo : '0;
                    r.position          = POS_W'(held_count);
                    held_count++;
                    r.keep    = 1'b1;
                    r.verdict = VERDICT_KEPT;
                end
            end
            r.kept_count = KEPT_W'(held_count);
            return r;
        endfunction

        function void note_request(logic sol, logic [FAMILY_W-1:0] fam,
                                   logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo);
            verdict_rec_t r;
            r = predict_verdict(sol, fam, hi, lo);
            awaited_verdicts.push_back(r);
            request_count++;
            if (sol) list_starts++;
            verdict_tally[r.verdict]++;
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
            mismatch_count++;
        endtask

        task check_result(logic [M_DATA_W-1:0] tdata, logic [M_USER_W-1:0] tuser);
            verdict_rec_t w;
            if (awaited_verdicts.size() == 0) begin
                report_mismatch("result with no request pending, tuser", tuser, 0);
            end else begin
                w = awaited_verdicts.pop_front();
                if (tuser[0] !== w.keep)
                    report_mismatch("keep", tuser[0], w.keep);
                if (tuser[2:1] !== w.verdict)
                    report_mismatch("verdict", tuser[2:1], w.verdict);
                if (tdata[POS_W-1:0] !== w.position)
                    report_mismatch("position", tdata[POS_W-1:0], w.position);
                if (tdata[POS_W+KEPT_W-1:POS_W] !== w.kept_count)
                    report_mismatch("kept_count", tdata[POS_W+KEPT_W-1:POS_W], w.kept_count);
                if (tdata[M_DATA_W-1:POS_W+KEPT_W] !== '0)
                    report_mismatch("pad", tdata[M_DATA_W-1:POS_W+KEPT_W], 0);
            end
        endtask
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    logic            fast_phase = 1'b0;
    dedup_scoreboard sb;

    always #5 aclk = ~aclk;

    address_list_dedup_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    task send_request(input logic sol, input logic [FAMILY_W-1:0] fam,
                      input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo);
        int gap;
        gap = fast_phase ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        s_tuser  <= {fam, sol};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(sol, fam, hi, lo);
    endtask

    task wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // result side with random stalls
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = fast_phase ? 0 : $urandom_range(0, 15);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [FAMILY_W-1:0] pool_fam [POOL_MAX];
        logic [ADDR_W-1:0]   pool_hi [POOL_MAX];
        logic [ADDR_W-1:0]   pool_lo [POOL_MAX];
        int                  list_idx;
        int                  list_len;
        int                  pool_size;
        int                  pick;
        int                  roll;
        logic                sol;
        logic [FAMILY_W-1:0] fam;
        logic [ADDR_W-1:0]   hi;
        logic [ADDR_W-1:0]   lo;

        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, ignored ipv4 bits, family mismatch, unsupported families
        send_request(1'b1, FAM_IPV4, 64'h0, 64'h0);
        send_request(1'b0, FAM_IPV4, 64'h0000_0000_FFFF_FFFF, '1);
        send_request(1'b0, FAM_IPV6, 64'h0, 64'h0);
        send_request(1'b0, FAM_IPV6, '1, '1);
        send_request(1'b0, FAM_IPV6, '1, '1);
        send_request(1'b0, FAM_IPV4, '1, 64'h0);
        send_request(1'b0, FAM_IPV6, 64'hFFFF_FFFF_0000_0000, 64'h0);
        send_request(1'b0, FAM_UNSUP_A, 64'h1234, 64'h5678);
        for (int k = 0; k < 9; k++)
            send_request(1'b0, FAM_IPV4, {32'hC0A8_0000 + k, 32'h0}, 64'h0);
        send_request(1'b0, FAM_IPV4, 64'hC0A8_00FF_0000_0000, 64'h0);
        send_request(1'b0, FAM_IPV6, '1, '1);
        send_request(1'b0, FAM_IPV4, 64'hC0A8_0003_DEAD_BEEF, 64'h0);
        send_request(1'b1, FAM_UNSUP_B, '1, '1);
        send_request(1'b0, FAM_IPV6, 64'h2001_0DB8_0000_0000, 64'h1);

        // random lists drawn from small address pools
        list_idx = 0;
        while (sb.request_count < 620) begin
            if (list_idx == 3)
                wait_drained();
            fast_phase = ($urandom_range(0, 3) == 0);
            pool_size  = $urandom_range(1, POOL_MAX);
            list_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 36)
                                                     : $urandom_range(1, 16);
            for (int k = 0; k < pool_size; k++) begin
                pool_fam[k] = $urandom_range(0, 1) ? FAM_IPV6 : FAM_IPV4;
                pool_hi[k]  = {$urandom, $urandom};
                pool_lo[k]  = {$urandom, $urandom};
            end
            for (int n = 0; n < list_len; n++) begin
                sol  = (n == 0) || ($urandom_range(0, 49) == 0);
                roll = $urandom_range(0, 99);
                hi   = {$urandom, $urandom};
                lo   = {$urandom, $urandom};
                if (roll < 8) begin
                    fam = $urandom_range(0, 1) ? FAM_UNSUP_A : FAM_UNSUP_B;
                end else if (roll < 15) begin
                    fam = $urandom_range(0, 1) ? FAM_IPV6 : FAM_IPV4;
                end else begin
                    pick = $urandom_range(0, pool_size - 1);
                    fam  = pool_fam[pick];
                    if (fam == FAM_IPV6) begin
                        hi = pool_hi[pick];
                        lo = pool_lo[pick];
                    end else begin
                        hi[63:32] = pool_hi[pick][63:32];
                    end
                end
                send_request(sol, fam, hi, lo);
            end
            list_idx++;
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        fast_phase = 1'b0;

        wait_drained();
        repeat (MAX_ENTRIES + 8) @(posedge aclk);
        $display("run covered %0d requests over %0d list starts", sb.request_count,
                 sb.list_starts);
        $display("verdicts: kept %0d, duplicate %0d, unsupported %0d, table full %0d",
                 sb.verdict_tally[VERDICT_KEPT], sb.verdict_tally[VERDICT_DUPLICATE],
                 sb.verdict_tally[VERDICT_UNSUPPORTED], sb.verdict_tally[VERDICT_FULL]);
        if (sb.mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/adf_pkg.sv
rtl/adf_entry_ram.sv
rtl/address_list_dedup_filter.sv
test/tb_address_list_dedup_filter.sv
